FILE: hdl/milliseconds_to_calendar_macros.svh
// Assertion macros for the calendar converter RTL.
// Included by mtc_core, which carries the concurrent checks; needs nothing else.
`ifndef MILLISECONDS_TO_CALENDAR_MACROS_SVH
`define MILLISECONDS_TO_CALENDAR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mtc_pkg.sv
// Types, constants and microcode ROM of the calendar converter.
// No dependencies; used by mtc_core and milliseconds_to_calendar.
package mtc_pkg;

    localparam int ACC_W  = 49;   // time_ms width, also the divider shift register
    localparam int DAYS_W = 23;   // whole-day count after the time-of-day split
    localparam int YEAR_W = 16;   // year accumulator, covers the full year range
    localparam int ITER_W = 8;    // subtract loop counter
    localparam int K_W    = 18;   // widest constant in the microcode (days per 400 years)
    localparam int NB_W   = 6;    // divider step count
    localparam int REM_W  = 10;   // divider remainder, divisor at most 1000
    localparam int DIG_W  = 7;    // quotient digit; seven digits cover the accumulator
    localparam int RCP_W  = 26;   // reciprocal of the divisor, scaled by 2^RCP_SH
    localparam int RCP_SH = 30;
    localparam int PC_W   = 4;

    typedef logic [PC_W-1:0] t_pc;

    typedef enum logic [2:0] {
        OP_DIV,     // divide the accumulator by k, one 7-bit digit at a time
        OP_RANGE,   // latch day count, flag out of range, jump on error
        OP_SUB,     // subtract k from days while possible (at most three times with lim3), add yinc to year
        OP_MONTH,   // walk the month table
        OP_DONE     // hand the result over
    } t_op;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_MS,
        DST_SEC,
        DST_MIN,
        DST_HR,
        DST_Q100,
        DST_Q4,
        DST_Q1
    } t_dst;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [K_W-1:0]   k;
        logic [RCP_W-1:0] recip;  // ceil(2^RCP_SH / k) for the divide words
        logic [8:0]       yinc;
        logic [NB_W-1:0]  nsteps;
        logic             lim3;   // loop runs at most three times
        t_dst             dst;
        t_pc              jmp;
    } t_uword;

    typedef struct packed {
        logic [48:0] time_ms;
    } t_in_item;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millisecond;
        logic        range_error;
    } t_out_item;

    localparam t_pc PC_RANGE = 4'd4;
    localparam t_pc PC_DONE  = 4'd10;

    // Microcode program, one control word per step.
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{op: OP_DONE, k: '0, recip: '0, yinc: '0, nsteps: '0, lim3: 1'b0,
              dst: DST_NONE, jmp: '0};
        case (pc)
            4'd0: w = '{op: OP_DIV, k: 18'd1000, recip: 26'd1073742, yinc: '0,
                        nsteps: 6'd14, lim3: 1'b0, dst: DST_MS, jmp: '0};
            4'd1: w = '{op: OP_DIV, k: 18'd60, recip: 26'd17895698, yinc: '0,
                        nsteps: 6'd14, lim3: 1'b0, dst: DST_SEC, jmp: '0};
            4'd2: w = '{op: OP_DIV, k: 18'd60, recip: 26'd17895698, yinc: '0,
                        nsteps: 6'd14, lim3: 1'b0, dst: DST_MIN, jmp: '0};
            4'd3: w = '{op: OP_DIV, k: 18'd24, recip: 26'd44739243, yinc: '0,
                        nsteps: 6'd14, lim3: 1'b0, dst: DST_HR, jmp: '0};
            4'd4: w = '{op: OP_RANGE, k: '0, recip: '0, yinc: '0, nsteps: '0, lim3: 1'b0,
                        dst: DST_NONE, jmp: PC_DONE};
            4'd5: w = '{op: OP_SUB, k: 18'd146097, recip: '0, yinc: 9'd400, nsteps: '0,
                        lim3: 1'b0, dst: DST_NONE, jmp: '0};
            4'd6: w = '{op: OP_SUB, k: 18'd36524, recip: '0, yinc: 9'd100, nsteps: '0,
                        lim3: 1'b1, dst: DST_Q100, jmp: '0};
            4'd7: w = '{op: OP_SUB, k: 18'd1461, recip: '0, yinc: 9'd4, nsteps: '0,
                        lim3: 1'b0, dst: DST_Q4, jmp: '0};
            4'd8: w = '{op: OP_SUB, k: 18'd365, recip: '0, yinc: 9'd1, nsteps: '0,
                        lim3: 1'b1, dst: DST_Q1, jmp: '0};
            4'd9: w = '{op: OP_MONTH, k: '0, recip: '0, yinc: '0, nsteps: '0, lim3: 1'b0,
                        dst: DST_NONE, jmp: '0};
            default: w = '{op: OP_DONE, k: '0, recip: '0, yinc: '0, nsteps: '0,
                           lim3: 1'b0, dst: DST_NONE, jmp: '0};
        endcase
        return w;
    endfunction

    // Month length, month index counted from zero.
    function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

FILE: hdl/mtc_stream_if.sv
// Valid/ready channel carrying one request or result payload.
// Payload type comes from mtc_pkg through the type parameter.
interface mtc_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/mtc_core.sv
// Microcoded sequencer and datapath of the calendar converter.
// Uses mtc_pkg (ROM, types) and milliseconds_to_calendar_macros.svh.
`include "milliseconds_to_calendar_macros.svh"

module mtc_core #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [48:0]        i_time_ms,
    output logic               o_idle,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output mtc_pkg::t_out_item o_res
);

    // First day after the last supported year
    localparam logic [24:0] DaysLimit =
        25'(MAX_YEAR * 365 + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400);

    // Digit divider widths: remainder and digit, then times the reciprocal
    localparam int VAL_W  = mtc_pkg::REM_W + mtc_pkg::DIG_W;
    localparam int PROD_W = VAL_W + mtc_pkg::RCP_W;

    mtc_pkg::t_state r_state, n_state;
    mtc_pkg::t_pc    r_pc, n_pc;

    logic [mtc_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic [mtc_pkg::REM_W-1:0]  r_rem, n_rem;
    logic [mtc_pkg::DIG_W-1:0]  r_qd, n_qd;
    logic [mtc_pkg::NB_W-1:0]   r_bit, n_bit;
    logic [mtc_pkg::DAYS_W-1:0] r_days, n_days;
    logic [mtc_pkg::YEAR_W-1:0] r_year, n_year;
    logic [mtc_pkg::ITER_W-1:0] r_iter, n_iter;
    logic [1:0]                 r_q100, n_q100;
    logic [4:0]                 r_q4, n_q4;
    logic [1:0]                 r_q1, n_q1;
    logic [3:0]                 r_month, n_month;
    logic                       r_err, n_err;
    logic [9:0]                 r_ms, n_ms;
    logic [5:0]                 r_sec, n_sec;
    logic [5:0]                 r_min, n_min;
    logic [4:0]                 r_hr, n_hr;

    mtc_pkg::t_uword w, nw;
    logic [VAL_W-1:0]          div_val;
    logic [PROD_W-1:0]         div_prod;
    logic [mtc_pkg::DIG_W-1:0] div_q;
    logic [VAL_W-1:0]          div_back;
    logic [mtc_pkg::REM_W-1:0] div_rem;
    logic                      sub_go;
    logic                      leap;
    logic [4:0]                mlen;
    logic                      mon_go;
    logic                      adv;
    logic                      take_jmp;

    // Control word and shared datapath terms
    always_comb begin
        w        = mtc_pkg::ucode(r_pc);
        // partial dividend: running remainder and the next digit of the accumulator
        div_val  = {r_rem, r_acc[mtc_pkg::ACC_W-1 -: mtc_pkg::DIG_W]};
        // reciprocal is rounded up, exact for every partial dividend below 128 * k
        div_prod = PROD_W'(div_val) * PROD_W'(w.recip);
        div_q    = div_prod[mtc_pkg::RCP_SH +: mtc_pkg::DIG_W];
        div_back = VAL_W'(r_qd) * VAL_W'(w.k[mtc_pkg::REM_W-1:0]);
        div_rem  = mtc_pkg::REM_W'(div_val - div_back);
        sub_go   = (r_days >= {5'b0, w.k}) && !(w.lim3 && (r_iter == 8'd3));
        // leap iff last year of a 4-year cycle, not the 100th year unless the 400th
        leap     = (r_q1 == 2'd3) && ((r_q4 != 5'd24) || (r_q100 == 2'd3));
        mlen     = mtc_pkg::month_len(leap, r_month);
        mon_go   = (r_month != 4'd11) && (r_days >= {18'b0, mlen});
    end

    // Sequencer: next state, step counter and datapath updates
    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_qd     = r_qd;
        n_bit    = r_bit;
        n_days   = r_days;
        n_year   = r_year;
        n_iter   = r_iter;
        n_q100   = r_q100;
        n_q4     = r_q4;
        n_q1     = r_q1;
        n_month  = r_month;
        n_err    = r_err;
        n_ms     = r_ms;
        n_sec    = r_sec;
        n_min    = r_min;
        n_hr     = r_hr;
        o_idle      = 1'b0;
        o_res_valid = 1'b0;
        adv      = 1'b0;
        take_jmp = 1'b0;

        case (r_state)
            mtc_pkg::ST_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_state = mtc_pkg::ST_RUN;
                    n_acc   = i_time_ms;
                    n_year  = '0;
                    n_month = '0;
                    n_err   = 1'b0;
                end
            end
            mtc_pkg::ST_RUN: begin
                case (w.op)
                    mtc_pkg::OP_DIV: begin
                        // odd step: quotient digit; even step: remainder and shift
                        if (r_bit[0]) begin
                            n_qd = div_q;
                        end else begin
                            n_rem = div_rem;
                            n_acc = {r_acc[mtc_pkg::ACC_W-mtc_pkg::DIG_W-1:0], r_qd};
                        end
                        n_bit = r_bit - 6'd1;
                        if (r_bit == '0) begin
                            adv = 1'b1;
                            case (w.dst)
                                mtc_pkg::DST_MS:  n_ms  = div_rem;
                                mtc_pkg::DST_SEC: n_sec = div_rem[5:0];
                                mtc_pkg::DST_MIN: n_min = div_rem[5:0];
                                mtc_pkg::DST_HR:  n_hr  = div_rem[4:0];
                                default: ;
                            endcase
                        end
                    end
                    mtc_pkg::OP_RANGE: begin
                        n_days   = r_acc[mtc_pkg::DAYS_W-1:0];
                        n_err    = r_acc >= {24'b0, DaysLimit};
                        adv      = 1'b1;
                        take_jmp = n_err;
                    end
                    mtc_pkg::OP_SUB: begin
                        if (sub_go) begin
                            n_days = r_days - {5'b0, w.k};
                            n_year = r_year + {7'b0, w.yinc};
                            n_iter = r_iter + 8'd1;
                        end else begin
                            adv = 1'b1;
                            case (w.dst)
                                mtc_pkg::DST_Q100: n_q100 = r_iter[1:0];
                                mtc_pkg::DST_Q4:   n_q4   = r_iter[4:0];
                                mtc_pkg::DST_Q1:   n_q1   = r_iter[1:0];
                                default: ;
                            endcase
                        end
                    end
                    mtc_pkg::OP_MONTH: begin
                        if (mon_go) begin
                            n_days  = r_days - {18'b0, mlen};
                            n_month = r_month + 4'd1;
                        end else begin
                            adv = 1'b1;
                        end
                    end
                    mtc_pkg::OP_DONE: begin
                        o_res_valid = 1'b1;
                        if (i_res_ready) begin
                            n_state = mtc_pkg::ST_IDLE;
                        end
                    end
                    default: n_state = mtc_pkg::ST_IDLE;
                endcase
            end
            default: n_state = mtc_pkg::ST_IDLE;
        endcase

        // Step to the next word (or program start) and prime its counters
        if (r_state == mtc_pkg::ST_IDLE) begin
            n_pc = '0;
        end else if (adv) begin
            n_pc = take_jmp ? w.jmp : r_pc + 4'd1;
        end
        nw = mtc_pkg::ucode(n_pc);
        if (adv || (r_state == mtc_pkg::ST_IDLE)) begin
            n_bit  = nw.nsteps - 6'd1;
            n_rem  = '0;
            n_iter = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtc_pkg::ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_acc   <= n_acc;
        r_rem   <= n_rem;
        r_qd    <= n_qd;
        r_bit   <= n_bit;
        r_days  <= n_days;
        r_year  <= n_year;
        r_iter  <= n_iter;
        r_q100  <= n_q100;
        r_q4    <= n_q4;
        r_q1    <= n_q1;
        r_month <= n_month;
        r_err   <= n_err;
        r_ms    <= n_ms;
        r_sec   <= n_sec;
        r_min   <= n_min;
        r_hr    <= n_hr;
    end

    // Result; everything but the flag reads zero when out of range
    always_comb begin
        o_res.range_error = r_err;
        if (r_err) begin
            o_res.year        = '0;
            o_res.month       = '0;
            o_res.day         = '0;
            o_res.hour        = '0;
            o_res.minute      = '0;
            o_res.second      = '0;
            o_res.millisecond = '0;
        end else begin
            o_res.year        = 14'(r_year + 16'd1);
            o_res.month       = r_month + 4'd1;
            o_res.day         = r_days[4:0] + 5'd1;
            o_res.hour        = r_hr;
            o_res.minute      = r_min;
            o_res.second      = r_sec;
            o_res.millisecond = r_ms;
        end
    end

    `MTC_ASSERT_NEXT(a_start_at_zero, i_clk, i_rst_n,
        (r_state == mtc_pkg::ST_IDLE) && i_start,
        (r_state == mtc_pkg::ST_RUN) && (r_pc == '0), "sequencer did not start at step zero")
    `MTC_ASSERT_IMPL(a_month_bound, i_clk, i_rst_n,
        r_state == mtc_pkg::ST_RUN, r_month <= 4'd11, "month index past December")
    `MTC_ASSERT_IMPL(a_short_loop, i_clk, i_rst_n,
        (r_state == mtc_pkg::ST_RUN) && (w.op == mtc_pkg::OP_SUB) && w.lim3,
        r_iter <= 8'd3, "century or year loop ran more than three times")
    `MTC_ASSERT_IMPL(a_error_zeroes, i_clk, i_rst_n,
        o_res_valid && o_res.range_error,
        (o_res.year == '0) && (o_res.month == '0) && (o_res.day == '0),
        "out-of-range result carries a date")

endmodule

FILE: hdl/milliseconds_to_calendar.sv
// Millisecond timestamp to proleptic Gregorian date and time converter.
//
// Requests arrive on i_in (valid/ready, payload time_ms: milliseconds since
// 0001-01-01 00:00:00.000); one result per request leaves on o_out with year,
// month, day, hour, minute, second, millisecond and range_error.
// A request is taken only while the sequencer is idle, one at a time.
// Each request goes through division by 1000, 60, 60 and 24 (seven 7-bit
// digits each), one range check, then subtract loops over 400/100/4/1-year
// spans and months; the loop counts of the subtract steps set how long it
// takes, and a request that raises the range flag skips the loops. With a free
// output a new request is taken in the cycle after each result is handed over.
// Results beyond year MAX_YEAR come back with range_error set and all other
// fields zero.
// A result sits in an output register; the next request may be accepted while
// it waits. If the receiver stalls and a second result is ready, the sequencer
// holds it until the output register frees up.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the output register.
// Depends on mtc_pkg, mtc_stream_if and mtc_core.

module milliseconds_to_calendar #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mtc_stream_if.sink   i_in,
    mtc_stream_if.source o_out
);

    logic               core_idle;
    logic               core_res_valid;
    logic               core_res_ready;
    mtc_pkg::t_out_item core_res;

    mtc_pkg::t_out_item r_out;
    logic               r_out_valid;

    mtc_core #(
        .MAX_YEAR (MAX_YEAR)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_in.valid && core_idle),
        .i_time_ms   (i_in.data.time_ms),
        .o_idle      (core_idle),
        .o_res_valid (core_res_valid),
        .i_res_ready (core_res_ready),
        .o_res       (core_res)
    );

    assign i_in.ready     = core_idle;
    assign core_res_ready = !r_out_valid || o_out.ready;

    // Output register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res_valid && core_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (core_res_valid && core_res_ready) begin
            r_out <= core_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

FILE: bench/milliseconds_to_calendar_checker.sv
`timescale 1ns / 1ps
// Result checker for milliseconds_to_calendar: watches the request and result channels,
// predicts each date/time split and compares it with what the converter returns.
// Depends on mtc_pkg for the request and result layouts.
module milliseconds_to_calendar_checker #(
    parameter int unsigned MAX_YEAR = 9999
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  logic               i_req_ready,
    input  mtc_pkg::t_in_item  i_req,
    input  logic               i_res_valid,
    input  logic               i_res_ready,
    input  mtc_pkg::t_out_item i_res,
    output int                 o_mismatch_count,
    output int                 o_pending
);

    localparam longint unsigned DAYS_PER_400Y = 146097;
    localparam longint unsigned DAYS_PER_100Y = 36524;
    localparam longint unsigned DAYS_PER_4Y   = 1461;
    localparam longint unsigned DAYS_PER_YEAR = 365;

    typedef struct {
        logic [48:0]        time_ms;
        mtc_pkg::t_out_item date;
    } t_expected_date;

    t_expected_date expected_dates [$];
    int             mismatches = 0;
    int             pending = 0;
    int unsigned    month_len_common [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    assign o_mismatch_count = mismatches;
    assign o_pending        = pending;

    function automatic bit is_leap(longint unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // Days contained in years 1 through n.
    function automatic longint unsigned days_through_year(longint unsigned n);
        return n * 365 + n / 4 - n / 100 + n / 400;
    endfunction

    // Split a millisecond stamp into calendar date and time of day.
    function automatic mtc_pkg::t_out_item calendar_from_ms(logic [48:0] stamp);
        longint unsigned    total, secs, mins, hrs, days, year;
        longint unsigned    q400, q100, q4, q1;
        int unsigned        month, mlen;
        mtc_pkg::t_out_item date;
        total = {15'b0, stamp};
        date  = '0;
        secs  = total / 1000;
        mins  = secs / 60;
        hrs   = mins / 60;
        days  = hrs / 24;
        // past the last supported year: flag only, everything else zero
        if (days >= days_through_year(64'(MAX_YEAR))) begin
            date.range_error = 1'b1;
            return date;
        end
        date.millisecond = 10'(total % 1000);
        date.second      = 6'(secs % 60);
        date.minute      = 6'(mins % 60);
        date.hour        = 5'(hrs % 24);

        // peel off 400/100/4/1-year spans; the last day of a span clamps to 3
        q400 = days / DAYS_PER_400Y;
        days = days % DAYS_PER_400Y;
        q100 = days / DAYS_PER_100Y;
        if (q100 > 3) q100 = 3;
        days = days - q100 * DAYS_PER_100Y;
        q4   = days / DAYS_PER_4Y;
        days = days % DAYS_PER_4Y;
        q1   = days / DAYS_PER_YEAR;
        if (q1 > 3) q1 = 3;
        days = days - q1 * DAYS_PER_YEAR;
        year = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;

        // walk the month lengths of that year
        month = 0;
        mlen  = month_len_common[0];
        while (month < 11 && days >= mlen) begin
            days  = days - mlen;
            month = month + 1;
            mlen  = month_len_common[month] + ((month == 1 && is_leap(year)) ? 1 : 0);
        end
        date.year  = 14'(year);
        date.month = 4'(month + 1);
        date.day   = 5'(days + 1);
        return date;
    endfunction

    function automatic string date_text(mtc_pkg::t_out_item d);
        return $sformatf("%0d-%0d-%0d %0d:%0d:%0d.%0d range_error=%0b", d.year, d.month,
                         d.day, d.hour, d.minute, d.second, d.millisecond, d.range_error);
    endfunction

    // Compare each accepted result with the oldest prediction, then log new requests.
    always @(posedge i_clk) begin
        t_expected_date want;
        if (i_rst_n) begin
            if (i_res_valid && i_res_ready) begin
                if (expected_dates.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("%0t: result with no request waiting: %s", $time,
                                 date_text(i_res));
                end else begin
                    want = expected_dates.pop_front();
                    if (i_res.year !== want.date.year || i_res.month !== want.date.month ||
                        i_res.day !== want.date.day || i_res.hour !== want.date.hour ||
                        i_res.minute !== want.date.minute ||
                        i_res.second !== want.date.second ||
                        i_res.millisecond !== want.date.millisecond ||
                        i_res.range_error !== want.date.range_error) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("%0t: time_ms %0d expected %s got %s", $time,
                                     want.time_ms, date_text(want.date), date_text(i_res));
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                expected_dates.push_back('{time_ms: i_req.time_ms,
                                           date: calendar_from_ms(i_req.time_ms)});
        end
        pending = expected_dates.size();
    end

endmodule

FILE: bench/milliseconds_to_calendar_tb.sv
`timescale 1ns / 1ps
// Testbench top for milliseconds_to_calendar: clock, reset, timestamp requests,
// result backpressure and the verdict. Needs mtc_pkg, mtc_stream_if, the converter
// RTL and milliseconds_to_calendar_checker.
module milliseconds_to_calendar_tb;

    localparam int unsigned     MAX_YEAR   = 9999;
    localparam longint unsigned MS_PER_DAY = 64'd86400000;
    localparam longint unsigned LAST_MS    = 64'd315537897599999;
    localparam int              N_RANDOM   = 750;

    logic i_clk;
    logic i_rst_n;
    int   mismatch_count;
    int   pending_count;

    mtc_stream_if #(.T(mtc_pkg::t_in_item))  req_if ();
    mtc_stream_if #(.T(mtc_pkg::t_out_item)) res_if ();

    milliseconds_to_calendar #(.MAX_YEAR(MAX_YEAR)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if.sink),
        .o_out   (res_if.source)
    );

    milliseconds_to_calendar_checker #(.MAX_YEAR(MAX_YEAR)) u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (req_if.valid),
        .i_req_ready      (req_if.ready),
        .i_req            (req_if.data),
        .i_res_valid      (res_if.valid),
        .i_res_ready      (res_if.ready),
        .i_res            (res_if.data),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the converter hangs.
    initial begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic bit leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned month_days(int unsigned y, int unsigned mo);
        case (mo)
            2:             return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // Millisecond stamp of a calendar date and time.
    function automatic longint unsigned stamp_ms(int unsigned y, int unsigned mo,
                                                 int unsigned d, int unsigned h,
                                                 int unsigned mi, int unsigned s,
                                                 int unsigned ms);
        longint unsigned days, py;
        int unsigned     m;
        py   = 64'(y) - 1;
        days = py * 365 + py / 4 - py / 100 + py / 400;
        for (m = 1; m < mo; m++)
            days = days + month_days(y, m);
        days = days + d - 1;
        return (((days * 24 + h) * 60 + mi) * 60 + s) * 1000 + ms;
    endfunction

    // Mostly no gap, some short ones, a few long.
    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // Random date, leaning toward month ends, century years and day boundaries.
    function automatic longint unsigned random_date_ms();
        int unsigned y, mo, d, h, mi, s, ms, last;
        if ($urandom_range(0, 3) == 0)
            y = 100 * $urandom_range(1, 99);
        else
            y = $urandom_range(1, MAX_YEAR);
        mo   = $urandom_range(1, 12);
        last = month_days(y, mo);
        case ($urandom_range(0, 2))
            0:       d = 1;
            1:       d = last;
            default: d = $urandom_range(1, last);
        endcase
        case ($urandom_range(0, 3))
            0: begin
                h = 0; mi = 0; s = 0; ms = 0;
            end
            1: begin
                h = 23; mi = 59; s = 59; ms = 999;
            end
            default: begin
                h  = $urandom_range(0, 23);
                mi = $urandom_range(0, 59);
                s  = $urandom_range(0, 59);
                ms = $urandom_range(0, 999);
            end
        endcase
        return stamp_ms(y, mo, d, h, mi, s, ms);
    endfunction

    function automatic logic [48:0] random_stamp();
        longint unsigned raw;
        int unsigned     r;
        raw = {$urandom, $urandom};
        r   = $urandom_range(0, 99);
        if (r < 40) return 49'(random_date_ms());
        if (r < 70) return 49'(raw % (LAST_MS + 1));
        if (r < 80) return 49'(raw % (5 * 366 * MS_PER_DAY));
        if (r < 92) return 49'(raw);
        // around the end of the supported range
        return 49'(LAST_MS + 1 - 500000 + $urandom_range(0, 999999));
    endfunction

    // Drive one request after an optional gap; returns at the falling edge after acceptance.
    task automatic send_request(logic [48:0] stamp, int unsigned gap);
        if (gap != 0) begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid        = 1'b1;
        req_if.data.time_ms = stamp;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    // Request side: reset, directed stamps, random stamps, drain, verdict.
    initial begin
        logic [48:0] directed_ms [$];
        bit          steady;
        int unsigned mo;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        i_rst_n      = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_ms.push_back('0);
        directed_ms.push_back(49'(LAST_MS));
        directed_ms.push_back(49'(LAST_MS + 1));
        directed_ms.push_back({49{1'b1}});
        directed_ms.push_back(49'(stamp_ms(1, 12, 31, 23, 59, 59, 999)));
        // leap day in a plain leap year
        directed_ms.push_back(49'(stamp_ms(4, 2, 29, 12, 34, 56, 789)));
        // day 366 of a leap year closing a 4-year span
        directed_ms.push_back(49'(stamp_ms(4, 12, 31, 23, 59, 59, 999)));
        // century year that is not leap
        directed_ms.push_back(49'(stamp_ms(100, 2, 28, 23, 59, 59, 999)));
        directed_ms.push_back(49'(stamp_ms(100, 3, 1, 0, 0, 0, 0)));
        // last day of a 400-year cycle, then the first of the next
        directed_ms.push_back(49'(stamp_ms(400, 12, 31, 23, 59, 59, 999)));
        directed_ms.push_back(49'(stamp_ms(401, 1, 1, 0, 0, 0, 0)));
        directed_ms.push_back(49'(stamp_ms(2000, 2, 29, 6, 30, 0, 0)));
        directed_ms.push_back(49'(stamp_ms(1900, 3, 1, 0, 0, 0, 1)));
        // last day of every month of a leap year
        for (mo = 1; mo <= 12; mo++)
            directed_ms.push_back(49'(stamp_ms(2024, mo, month_days(2024, mo), mo, mo * 4,
                                                59 - mo, 999 - mo)));

        foreach (directed_ms[i])
            send_request(directed_ms[i], ($urandom_range(0, 2) == 0) ? idle_cycles() : 0);

        steady = 1'b0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 64 == 0)
                steady = ($urandom_range(0, 3) == 0);
            send_request(random_stamp(), steady ? 0 : idle_cycles());
        end
        req_if.valid = 1'b0;

        while (pending_count != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Result side: random stalls, with occasional long stretches of steady ready.
    initial begin
        int unsigned gap;
        res_if.ready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            res_if.ready = 1'b1;
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(100, 600)) @(negedge i_clk);
            end else begin
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
                gap = idle_cycles();
                if (gap != 0) begin
                    res_if.ready = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
    end

endmodule
